@@ rtl/crc8fd_pkg.sv @@
// Package for the CRC-8 frame decoder: sizes, register indexes, status and
// emit codes, controller/datapath structs and the CRC-8 byte update.
// No dependencies.
package crc8fd_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
   localparam logic [7:0]       CRC_POLY = 8'h31;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 1'd1;

   localparam logic [7:0]       START_BYTE_RESET = 8'hAA;
   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 6'd32;

   // Result status codes.
   localparam logic [1:0] ST_GOOD = 2'd0;
   localparam logic [1:0] ST_CRC  = 2'd1;
   localparam logic [1:0] ST_LEN  = 2'd2;

   // Kinds of result the controller asks the datapath to load.
   localparam logic [2:0] EMIT_NONE      = 3'd0;
   localparam logic [2:0] EMIT_LEN_ERR   = 3'd1;
   localparam logic [2:0] EMIT_CRC_ERR   = 3'd2;
   localparam logic [2:0] EMIT_GOOD_ZERO = 3'd3;
   localparam logic [2:0] EMIT_PAYLOAD   = 3'd4;

   typedef struct packed {
      logic       clear_crc;
      logic       load_type;
      logic       load_len;
      logic       store_byte;
      logic       upd_crc;
      logic       drain_start;
      logic       rd_en;
      logic       advance;
      logic [2:0] emit;
   } dp_cmd_type;

   typedef struct packed {
      logic start_match;
      logic len_over;
      logic len_zero;
      logic fill_done;
      logic crc_ok;
      logic held_zero;
      logic out_free;
      logic drain_last;
   } dp_status_type;

   // CRC-8, MSB first, no reflection, no final xor.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/crc8fd_req_if.sv @@
// Input channel of the CRC-8 frame decoder: one received byte per beat.
// Depends on crc8fd_pkg.
interface crc8fd_req_if;
   import crc8fd_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/crc8fd_rsp_if.sv @@
// Result channel of the CRC-8 frame decoder: one result per beat.
// Depends on crc8fd_pkg.
interface crc8fd_rsp_if;
   import crc8fd_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [7:0]        frame_type;
   logic [LEN_W-1:0]  frame_length;
   logic              has_payload;
   logic [ADDR_W-1:0] byte_index;
   logic [7:0]        payload_byte;
   logic              last;

   modport source (output valid, output status, output frame_type, output frame_length,
                   output has_payload, output byte_index, output payload_byte,
                   output last, input ready);
   modport sink (input valid, input status, input frame_type, input frame_length,
                 input has_payload, input byte_index, input payload_byte,
                 input last, output ready);
endinterface

@@ rtl/crc8fd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crc8fd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/crc8fd_ctrl.sv @@
// Frame controller: walks start, type, length, payload and check bytes and
// sequences the payload drain. Depends on crc8fd_pkg.
module crc8fd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  crc8fd_pkg::dp_status_type status,
   output crc8fd_pkg::dp_cmd_type    cmd
);
   import crc8fd_pkg::*;

   localparam logic [2:0] S_HUNT     = 3'd0;
   localparam logic [2:0] S_TYPE     = 3'd1;
   localparam logic [2:0] S_LEN      = 3'd2;
   localparam logic [2:0] S_DATA     = 3'd3;
   localparam logic [2:0] S_CHECK    = 3'd4;
   localparam logic [2:0] S_DRAIN_RD = 3'd5;
   localparam logic [2:0] S_DRAIN_LD = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       beat;

   assign beat = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.emit  = EMIT_NONE;
      case (state_ff)
         S_HUNT: begin
            req_ready = 1'b1;
            if (beat && status.start_match) begin
               cmd.clear_crc = 1'b1;
               state_in      = S_TYPE;
            end
         end
         S_TYPE: begin
            req_ready = 1'b1;
            if (beat) begin
               cmd.load_type = 1'b1;
               cmd.upd_crc   = 1'b1;
               state_in      = S_LEN;
            end
         end
         S_LEN: begin
            req_ready = status.out_free;
            if (beat) begin
               if (status.len_over) begin
                  cmd.emit = EMIT_LEN_ERR;
                  state_in = S_HUNT;
               end else begin
                  cmd.load_len = 1'b1;
                  cmd.upd_crc  = 1'b1;
                  state_in     = status.len_zero ? S_CHECK : S_DATA;
               end
            end
         end
         S_DATA: begin
            req_ready = 1'b1;
            if (beat) begin
               cmd.store_byte = 1'b1;
               cmd.upd_crc    = 1'b1;
               if (status.fill_done) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            req_ready = status.out_free;
            if (beat) begin
               if (!status.crc_ok) begin
                  cmd.emit = EMIT_CRC_ERR;
                  state_in = S_HUNT;
               end else if (status.held_zero) begin
                  cmd.emit = EMIT_GOOD_ZERO;
                  state_in = S_HUNT;
               end else begin
                  cmd.drain_start = 1'b1;
                  state_in        = S_DRAIN_RD;
               end
            end
         end
         S_DRAIN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DRAIN_LD;
         end
         S_DRAIN_LD: begin
            // The next byte is fetched in the same cycle its predecessor is
            // loaded, so the drain gives one result per cycle when unstalled.
            if (status.out_free) begin
               cmd.emit = EMIT_PAYLOAD;
               if (status.drain_last) begin
                  state_in = S_HUNT;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_rd_then_ld: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN_RD |=> state_ff == S_DRAIN_LD)
      else $error("drain read not followed by load");

   a_no_beat_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN_RD || state_ff == S_DRAIN_LD) |-> cmd.emit != EMIT_LEN_ERR
         && cmd.emit != EMIT_CRC_ERR && !cmd.store_byte)
      else $error("frame byte handled during drain");
endmodule

@@ rtl/crc8fd_dp.sv @@
// Frame datapath: configuration registers, held type and length, running
// CRC, payload RAM and the result register. Depends on crc8fd_pkg, crc8fd_ram.
module crc8fd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [crc8fd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crc8fd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [7:0]                           rx_byte,
   input  crc8fd_pkg::dp_cmd_type               cmd,
   output crc8fd_pkg::dp_status_type            status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [7:0]                           rsp_frame_type,
   output logic [crc8fd_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic                                 rsp_has_payload,
   output logic [crc8fd_pkg::ADDR_W-1:0]        rsp_byte_index,
   output logic [7:0]                           rsp_payload_byte,
   output logic                                 rsp_last
);
   import crc8fd_pkg::*;

   logic [7:0]        start_byte_ff;
   logic [LEN_W-1:0]  max_length_ff;
   logic [7:0]        held_type_ff;
   logic [LEN_W-1:0]  held_length_ff;
   logic [LEN_W-1:0]  fill_count_ff;
   logic [7:0]        crc_ff;
   logic [ADDR_W-1:0] drain_cnt_ff;
   logic              valid_ff;
   logic [1:0]        status_ff;
   logic [7:0]        type_ff;
   logic [LEN_W-1:0]  length_ff;
   logic              has_ff;
   logic [ADDR_W-1:0] index_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;

   logic [LEN_W-1:0]  limit;
   logic [LEN_W-1:0]  sat_length;
   logic [LEN_W:0]    fill_next;
   logic [LEN_W:0]    drain_next;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   assign limit      = (max_length_ff > MAX_LEN) ? MAX_LEN : max_length_ff;
   assign sat_length = (|rx_byte[7:LEN_W]) ? '1 : rx_byte[LEN_W-1:0];
   assign fill_next  = {1'b0, fill_count_ff} + 1'b1;
   assign drain_next = {2'b00, drain_cnt_ff} + 1'b1;
   assign rd_addr    = cmd.advance ? drain_next[ADDR_W-1:0] : drain_cnt_ff;

   always_comb begin
      status.start_match = rx_byte == start_byte_ff;
      status.len_over    = rx_byte > {{(8-LEN_W){1'b0}}, limit};
      status.len_zero    = rx_byte == 8'd0;
      status.fill_done   = fill_next >= {1'b0, held_length_ff};
      status.crc_ok      = rx_byte == crc_ff;
      status.held_zero   = held_length_ff == '0;
      status.out_free    = !valid_ff || rsp_ready;
      status.drain_last  = drain_next == {1'b0, held_length_ff};
   end

   crc8fd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (fill_count_ff[ADDR_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RESET;
         max_length_ff  <= MAX_LENGTH_RESET;
         held_type_ff   <= '0;
         held_length_ff <= '0;
         fill_count_ff  <= '0;
         crc_ff         <= '0;
         drain_cnt_ff   <= '0;
         valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_BYTE: start_byte_ff <= csr_wdata;
               CSR_MAX_LENGTH: max_length_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load_type) begin
            held_type_ff <= rx_byte;
         end
         if (cmd.load_len) begin
            held_length_ff <= rx_byte[LEN_W-1:0];
            fill_count_ff  <= '0;
         end else if (cmd.store_byte) begin
            fill_count_ff <= fill_next[LEN_W-1:0];
         end
         if (cmd.clear_crc) begin
            crc_ff <= '0;
         end else if (cmd.upd_crc) begin
            crc_ff <= crc8_update(crc_ff, rx_byte);
         end
         if (cmd.drain_start) begin
            drain_cnt_ff <= '0;
         end else if (cmd.advance) begin
            drain_cnt_ff <= drain_next[ADDR_W-1:0];
         end
         if (cmd.emit != EMIT_NONE) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: loaded only on an emit command.
   always_ff @(posedge clock) begin
      if (cmd.emit != EMIT_NONE) begin
         type_ff  <= held_type_ff;
         has_ff   <= 1'b0;
         index_ff <= '0;
         byte_ff  <= '0;
         last_ff  <= 1'b1;
         case (cmd.emit)
            EMIT_LEN_ERR: begin
               status_ff <= ST_LEN;
               length_ff <= sat_length;
            end
            EMIT_CRC_ERR: begin
               status_ff <= ST_CRC;
               length_ff <= held_length_ff;
            end
            EMIT_PAYLOAD: begin
               status_ff <= ST_GOOD;
               length_ff <= held_length_ff;
               has_ff    <= 1'b1;
               index_ff  <= drain_cnt_ff;
               byte_ff   <= rd_data;
               last_ff   <= status.drain_last;
            end
            default: begin
               status_ff <= ST_GOOD;
               length_ff <= held_length_ff;
            end
         endcase
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_type   = type_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_has_payload  = has_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_last         = last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> cmd.emit == EMIT_NONE)
      else $error("waiting result overwritten");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      held_length_ff <= MAX_LEN)
      else $error("held length above payload capacity");

   a_store_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.store_byte |-> fill_count_ff < held_length_ff)
      else $error("payload byte stored past frame length");
endmodule

@@ rtl/crc8_frame_decoder.sv @@
// Top level of the CRC-8 frame decoder: controller plus datapath.
// Depends on crc8fd_pkg, crc8fd_req_if, crc8fd_rsp_if, crc8fd_ctrl, crc8fd_dp.
//
//   Channel   Direction  Beat carries
//   req_chan  in         rx_byte
//   rsp_chan  out        status, frame_type, frame_length, has_payload,
//                        byte_index, payload_byte, last
//   csr_*     in         start_byte (index 0), max_length (index 1)
//
// The check byte of a good frame with payload holds off input while the
// payload RAM is read out, one result per cycle when the result channel
// is not stalled; a read state ahead of the first load covers the
// registered RAM read. Length and check bytes wait only when the result
// register is still full. Reset is synchronous and needs no clearing pass;
// a stalled result channel stalls the drain without losing data.
module crc8_frame_decoder (
   input  logic                              clock,
   input  logic                              reset,
   crc8fd_req_if.sink                        req_chan,
   crc8fd_rsp_if.source                      rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [crc8fd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [crc8fd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import crc8fd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   crc8fd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   crc8fd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rx_byte          (req_chan.rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_frame_type   (rsp_chan.frame_type),
      .rsp_frame_length (rsp_chan.frame_length),
      .rsp_has_payload  (rsp_chan.has_payload),
      .rsp_byte_index   (rsp_chan.byte_index),
      .rsp_payload_byte (rsp_chan.payload_byte),
      .rsp_last         (rsp_chan.last)
   );
endmodule

@@ tb/crc8fd_tb_pkg.sv @@
`timescale 1ns / 1ps
// Shared testbench helpers for the CRC-8 frame decoder: the bit-serial CRC-8
// used both to build frames and to predict the check. Depends on crc8fd_pkg.
package crc8fd_tb_pkg;
   import crc8fd_pkg::*;

   // Feeds the byte in one bit at a time, MSB first. This gives the same
   // result as xoring the whole byte in and then shifting eight times.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[7] ^ data[k];
         r  = {r[6:0], 1'b0};
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

endpackage

@@ tb/crc8fd_frame_checker.sv @@
`timescale 1ns / 1ps
// Checker for the CRC-8 frame decoder: watches the byte, result and register
// ports, predicts each result beat and compares it. Depends on crc8fd_pkg,
// crc8fd_tb_pkg and the two channel interfaces.
module crc8fd_frame_checker
   import crc8fd_pkg::*;
   import crc8fd_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   crc8fd_req_if                 req_mon,
   crc8fd_rsp_if                 rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    results_checked,
   output logic                  hunting
);

   typedef enum logic [2:0] {
      SEEK_START,
      READ_TYPE,
      READ_LEN,
      READ_DATA,
      READ_CRC
   } deframe_phase_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        frame_type;
      logic [LEN_W-1:0]  frame_length;
      logic              has_payload;
      logic [ADDR_W-1:0] byte_index;
      logic [7:0]        payload_byte;
      logic              last;
   } frame_result_type;

   logic [7:0]       start_q;
   logic [LEN_W-1:0] max_len_q;

   deframe_phase_type phase_q;
   logic [7:0]        type_q;
   logic [LEN_W-1:0]  len_q;
   logic [LEN_W-1:0]  fill_q;
   logic [7:0]        crc_q;
   logic [7:0]        payload_q [MAX_PAYLOAD];

   frame_result_type  pending_results [$];

   function automatic frame_result_type make_result(input logic [1:0] st, input logic [7:0] ty,
                                                    input logic [LEN_W-1:0] len, input logic has,
                                                    input logic [ADDR_W-1:0] idx,
                                                    input logic [7:0] data, input logic lst);
      frame_result_type r;
      r.status       = st;
      r.frame_type   = ty;
      r.frame_length = len;
      r.has_payload  = has;
      r.byte_index   = idx;
      r.payload_byte = data;
      r.last         = lst;
      return r;
   endfunction

   task automatic deframe_byte(input logic [7:0] b);
      int limit;
      limit = (max_len_q > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(max_len_q);
      case (phase_q)
         SEEK_START: begin
            if (b == start_q) begin
               crc_q   = 8'h00;
               phase_q = READ_TYPE;
            end
         end
         READ_TYPE: begin
            type_q  = b;
            crc_q   = crc8_next(crc_q, b);
            phase_q = READ_LEN;
         end
         READ_LEN: begin
            if (b > limit) begin
               // The reported length saturates at what six bits can hold.
               pending_results.push_back(make_result(ST_LEN, type_q,
                  (b > 8'd63) ? 6'd63 : b[LEN_W-1:0], 1'b0, '0, 8'h00, 1'b1));
               phase_q = SEEK_START;
            end else begin
               len_q   = b[LEN_W-1:0];
               fill_q  = '0;
               crc_q   = crc8_next(crc_q, b);
               phase_q = (b > 0) ? READ_DATA : READ_CRC;
            end
         end
         READ_DATA: begin
            if (fill_q < MAX_PAYLOAD) payload_q[fill_q[ADDR_W-1:0]] = b;
            fill_q = fill_q + 1'b1;
            crc_q  = crc8_next(crc_q, b);
            if (fill_q >= len_q) phase_q = READ_CRC;
         end
         READ_CRC: begin
            if (b != crc_q) begin
               pending_results.push_back(make_result(ST_CRC, type_q, len_q, 1'b0, '0,
                                                     8'h00, 1'b1));
            end else if (len_q == 0) begin
               pending_results.push_back(make_result(ST_GOOD, type_q, '0, 1'b0, '0,
                                                     8'h00, 1'b1));
            end else begin
               for (int i = 0; i < len_q && i < MAX_PAYLOAD; i++) begin
                  pending_results.push_back(make_result(ST_GOOD, type_q, len_q, 1'b1,
                     ADDR_W'(i), payload_q[i], (i + 1 == len_q)));
               end
            end
            phase_q = SEEK_START;
         end
         default: phase_q = SEEK_START;
      endcase
   endtask

   task automatic check_result();
      frame_result_type got;
      frame_result_type want;
      got.status       = rsp_mon.status;
      got.frame_type   = rsp_mon.frame_type;
      got.frame_length = rsp_mon.frame_length;
      got.has_payload  = rsp_mon.has_payload;
      got.byte_index   = rsp_mon.byte_index;
      got.payload_byte = rsp_mon.payload_byte;
      got.last         = rsp_mon.last;
      results_checked++;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"%t: result beat with nothing expected: st=%0d type=%02h len=%0d",
                      " has=%0d idx=%0d data=%02h last=%0d"},
                     $realtime, got.status, got.frame_type, got.frame_length,
                     got.has_payload, got.byte_index, got.payload_byte, got.last);
      end else begin
         want = pending_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%t: result mismatch", $realtime);
               $display("   expected st=%0d type=%02h len=%0d has=%0d idx=%0d data=%02h last=%0d",
                        want.status, want.frame_type, want.frame_length, want.has_payload,
                        want.byte_index, want.payload_byte, want.last);
               $display("   actual   st=%0d type=%02h len=%0d has=%0d idx=%0d data=%02h last=%0d",
                        got.status, got.frame_type, got.frame_length, got.has_payload,
                        got.byte_index, got.payload_byte, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_q         = START_BYTE_RESET;
         max_len_q       = MAX_LENGTH_RESET;
         phase_q         = SEEK_START;
         type_q          = 8'h00;
         len_q           = '0;
         fill_q          = '0;
         crc_q           = 8'h00;
         mismatches      = 0;
         results_checked = 0;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_BYTE: start_q   = csr_wdata;
               CSR_MAX_LENGTH: max_len_q = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) deframe_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_result();
      end
      outstanding = pending_results.size();
      hunting     = (phase_q == SEEK_START);
   end

endmodule

@@ tb/tb_crc8_frame_decoder.sv @@
`timescale 1ns / 1ps
// Top of the CRC-8 frame decoder testbench: clock, reset, byte and register
// stimulus, result back-pressure and the verdict. Depends on crc8fd_pkg,
// crc8fd_tb_pkg, the channel interfaces, crc8fd_frame_checker and the block.
module tb_crc8_frame_decoder;
   import crc8fd_pkg::*;
   import crc8fd_tb_pkg::*;

   typedef enum int {
      FLAW_NONE,
      FLAW_BAD_CRC,
      FLAW_CUT
   } frame_flaw_type;

   localparam int ITEMS_PER_PHASE = 10;
   localparam int RANDOM_PHASES   = 6;
   localparam int LONG_STALL      = 150;
   localparam int SETTLE_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT  = 1000;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   mismatches;
   int   outstanding;
   int   results_checked;
   logic hunting;

   int         req_gap_max    = 5;
   int         rsp_gap_max    = 5;
   int         stall_requests = 0;
   int         stalls_done    = 0;
   int         bytes_sent     = 0;
   int         settings_used  = 1;
   logic [7:0] cur_start      = START_BYTE_RESET;
   int         cur_limit      = int'(MAX_LENGTH_RESET);

   crc8fd_req_if req_chan ();
   crc8fd_rsp_if rsp_chan ();

   crc8_frame_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   crc8fd_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .hunting         (hunting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every task below is entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.rx_byte = value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // An over-limit length ends the frame after the length byte; a cut frame
   // stops early, so the bytes that follow are taken as its payload.
   task automatic send_frame(input logic [7:0] ftype, input int len, input frame_flaw_type flaw);
      logic [7:0] crc;
      logic [7:0] data;
      int         count;
      send_byte(cur_start);
      send_byte(ftype);
      send_byte(8'(len));
      if (len > cur_limit) return;
      crc   = crc8_next(crc8_next(8'h00, ftype), 8'(len));
      count = (flaw == FLAW_CUT) ? $urandom_range(0, len - 1) : len;
      for (int i = 0; i < count; i++) begin
         data = 8'($urandom);
         crc  = crc8_next(crc, data);
         send_byte(data);
      end
      if (flaw == FLAW_CUT) return;
      if (flaw == FLAW_BAD_CRC) crc = crc ^ 8'($urandom_range(1, 255));
      send_byte(crc);
   endtask

   task automatic send_random_item();
      int pick;
      int hi;
      int len;
      pick = $urandom_range(0, 99);
      hi   = (cur_limit < 6) ? cur_limit : 6;
      if (pick < 8) begin
         send_byte(8'($urandom));
      end else if (pick < 16) begin
         send_frame(8'($urandom), $urandom_range(cur_limit + 1, 255), FLAW_NONE);
      end else if (pick < 22) begin
         if (cur_limit > 0) send_frame(8'($urandom), $urandom_range(1, cur_limit), FLAW_CUT);
         else send_frame(8'($urandom), 0, FLAW_BAD_CRC);
      end else begin
         len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, cur_limit)
                                           : $urandom_range(0, hi);
         send_frame(8'($urandom), len,
                    ($urandom_range(0, 6) == 0) ? FLAW_BAD_CRC : FLAW_NONE);
      end
   endtask

   // Pads any unfinished frame until the decoder is hunting again, waits for
   // the last results, then lets the block settle before registers change.
   task automatic drain_and_pause();
      while (!hunting) send_byte(~cur_start);
      req_chan.valid = 1'b0;
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : result_sink
      int gap;
      rsp_chan.ready = 1'b0;
      forever begin
         if (stalls_done != stall_requests) begin
            rsp_chan.ready = 1'b0;
            repeat (LONG_STALL) @(negedge clock);
            stalls_done++;
         end
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_crc8_frame_decoder: errors");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] crc;
      int         base;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_START_BYTE;
      csr_wdata        = '0;
      reset            = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed frames under the reset settings.
      send_byte(8'hFF);
      send_frame(8'h00, 0, FLAW_NONE);
      send_frame(8'hFF, 33, FLAW_NONE);
      send_frame(8'h5C, 255, FLAW_NONE);
      send_frame(8'h3C, 1, FLAW_BAD_CRC);
      // The start byte as payload must not restart the frame.
      crc = crc8_next(crc8_next(crc8_next(8'h00, 8'h12), 8'd1), START_BYTE_RESET);
      send_byte(START_BYTE_RESET);
      send_byte(8'h12);
      send_byte(8'd1);
      send_byte(START_BYTE_RESET);
      send_byte(crc);
      crc = crc8_next(crc8_next(crc8_next(crc8_next(8'h00, 8'hA5), 8'd2), 8'h00), 8'hFF);
      send_byte(START_BYTE_RESET);
      send_byte(8'hA5);
      send_byte(8'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(crc);
      drain_and_pause();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         req_gap_max = 5;
         rsp_gap_max = 5;
         case (p)
            0: begin
               cur_start = 8'h00;
               cur_limit = 0;
            end
            1: begin
               cur_start   = 8'hFF;
               cur_limit   = MAX_PAYLOAD;
               req_gap_max = 0;
               rsp_gap_max = 0;
            end
            2: begin
               cur_start = 8'($urandom);
               cur_limit = $urandom_range(1, 31);
            end
            3: begin
               cur_start = START_BYTE_RESET;
               cur_limit = MAX_PAYLOAD;
            end
            4: begin
               cur_start = 8'($urandom);
               cur_limit = 1;
            end
            default: begin
               cur_start = 8'($urandom);
               cur_limit = $urandom_range(0, MAX_PAYLOAD);
            end
         endcase
         write_reg(CSR_START_BYTE, cur_start);
         write_reg(CSR_MAX_LENGTH, 8'(cur_limit));
         settings_used++;
         base = bytes_sent;
         // The long receiver stall lands on a full-size frame so the
         // decoder backs up into its input.
         if (p == 3) stall_requests++;
         if (cur_limit == MAX_PAYLOAD) send_frame(8'($urandom), MAX_PAYLOAD, FLAW_NONE);
         while (bytes_sent - base < ITEMS_PER_PHASE) send_random_item();
         drain_and_pause();
      end

      $display("Sent %0d bytes under %0d register settings and checked %0d result beats.",
               bytes_sent, settings_used, results_checked);
      $display("Frames covered good, zero-length, CRC-error, over-length and cut cases.");
      if (mismatches == 0 && outstanding == 0)
         $display("tb_crc8_frame_decoder: clean");
      else
         $display("tb_crc8_frame_decoder: errors");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/crc8fd_pkg.sv
rtl/crc8fd_req_if.sv
rtl/crc8fd_rsp_if.sv
rtl/crc8fd_ram.sv
rtl/crc8fd_ctrl.sv
rtl/crc8fd_dp.sv
rtl/crc8_frame_decoder.sv
tb/crc8fd_tb_pkg.sv
tb/crc8fd_frame_checker.sv
tb/tb_crc8_frame_decoder.sv
